// File: sv/vcsn_pkg.sv
// Shared types and constants for the vector clock snapshot node.
`timescale 1ns / 1ps

package vcsn_pkg;

    localparam int NUM_PROCS_DEF  = 3;
    localparam int CLOCK_BITS_DEF = 16;

    localparam int CMD_W    = 3;
    localparam int KIND_W   = 3;
    localparam int PEER_W   = 2;
    localparam int FIELD_W  = 16;
    localparam int NUM_ENT  = 3;
    localparam int RANK_W   = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    localparam logic REG_OWN_RANK = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INTERNAL = 3'd0,
        CMD_SEND     = 3'd1,
        CMD_RECV     = 3'd2,
        CMD_MARKER   = 3'd3,
        CMD_START    = 3'd4
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLOCK  = 3'd0,
        KIND_MSG    = 3'd1,
        KIND_RECORD = 3'd2,
        KIND_MARKER = 3'd3,
        KIND_DONE   = 3'd4,
        KIND_NOTED  = 3'd5
    } t_kind;

    // First result of one input item, plus whether markers follow it.
    typedef struct packed {
        t_kind                                kind;
        logic [PEER_W-1:0]                    peer;
        logic [NUM_ENT-1:0][FIELD_W-1:0]      clk;
        logic                                 in_snap;
        logic                                 has_markers;
    } t_desc;

endpackage

// File: sv/vcsn_core.sv
// Input register, clock and marker state, and per-item update logic.
`timescale 1ns / 1ps

module vcsn_core import vcsn_pkg::*; #(
    parameter int NUM_PROCS  = NUM_PROCS_DEF,
    parameter int CLOCK_BITS = CLOCK_BITS_DEF,
    localparam int IDX_W     = $clog2(NUM_PROCS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [CMD_W-1:0]              i_cmd,
    input  logic [PEER_W-1:0]             i_peer,
    input  logic [NUM_ENT-1:0][FIELD_W-1:0] i_recv,
    input  logic [RANK_W-1:0]             i_own_rank,
    output logic [IDX_W-1:0]              o_own_idx,
    output logic                          o_desc_valid,
    output t_desc                         o_desc,
    input  logic                          i_desc_done
);

    localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

    logic                         r_in_valid;
    logic [CMD_W-1:0]             r_cmd;
    logic [PEER_W-1:0]            r_peer;
    logic [NUM_ENT-1:0][FIELD_W-1:0] r_recv;

    logic [CLOCK_BITS-1:0]        r_clk [NUM_PROCS];
    logic [NUM_PROCS-1:0]         r_seen;
    logic                         r_active;
    logic                         r_desc_valid;
    t_desc                        r_desc;

    logic [CLOCK_BITS-1:0]        n_clk [NUM_PROCS];
    logic [NUM_PROCS-1:0]         n_seen;
    logic                         n_active;
    t_desc                        n_desc;
    logic                         n_desc_ok;

    logic [CLOCK_BITS-1:0]        recv_ext [NUM_PROCS];
    logic [IDX_W-1:0]             own_idx;
    logic                         fire;

    assign own_idx = (32'(i_own_rank) >= NUM_PROCS) ? IDX_W'(NUM_PROCS - 1)
                                                     : IDX_W'(i_own_rank);
    assign o_own_idx = own_idx;

    // Received entries beyond the three inputs count as zero.
    for (genvar g = 0; g < NUM_PROCS; g++) begin : g_recv
        if (g < NUM_ENT) begin : g_have
            assign recv_ext[g] = CLOCK_BITS'(r_recv[g]);
        end else begin : g_none
            assign recv_ext[g] = '0;
        end
    end

    assign fire         = r_in_valid && (!r_desc_valid || i_desc_done);
    assign o_in_ready   = !r_in_valid || fire;
    assign o_desc_valid = r_desc_valid;
    assign o_desc       = r_desc;

    always_comb begin
        for (int i = 0; i < NUM_PROCS; i++) begin
            n_clk[i] = r_clk[i];
        end
        n_seen    = r_seen;
        n_active  = r_active;
        n_desc_ok = 1'b1;
        n_desc    = '0;

        unique case (t_cmd'(r_cmd))
            CMD_INTERNAL, CMD_SEND, CMD_RECV: begin
                if (r_clk[own_idx] != CLK_MAX) begin
                    n_clk[own_idx] = r_clk[own_idx] + 1'b1;
                end
                if (t_cmd'(r_cmd) == CMD_RECV) begin
                    for (int i = 0; i < NUM_PROCS; i++) begin
                        if (i != int'(own_idx) && recv_ext[i] > r_clk[i]) begin
                            n_clk[i] = recv_ext[i];
                        end
                    end
                end
                n_desc.kind = (t_cmd'(r_cmd) == CMD_SEND) ? KIND_MSG : KIND_CLOCK;
                n_desc.peer = (t_cmd'(r_cmd) == CMD_INTERNAL) ? '0 : r_peer;
            end
            CMD_MARKER: begin
                for (int i = 0; i < NUM_PROCS; i++) begin
                    if (32'(r_peer) == i) begin
                        n_seen[i] = 1'b1;
                    end
                end
                n_desc.peer = r_peer;
                if (!r_active) begin
                    n_active           = 1'b1;
                    n_seen[own_idx]    = 1'b1;
                    n_desc.kind        = KIND_RECORD;
                    n_desc.has_markers = 1'b1;
                end else if (&n_seen) begin
                    n_active    = 1'b0;
                    n_seen      = '0;
                    n_desc.kind = KIND_DONE;
                end else begin
                    n_desc.kind = KIND_NOTED;
                end
            end
            CMD_START: begin
                n_active           = 1'b1;
                n_seen[own_idx]    = 1'b1;
                n_desc.kind        = KIND_RECORD;
                n_desc.peer        = PEER_W'(own_idx);
                n_desc.has_markers = 1'b1;
            end
            default: begin
                n_desc_ok = 1'b0;
            end
        endcase

        // Report the clock and snapshot flag after the update.
        for (int i = 0; i < NUM_ENT; i++) begin
            if (i < NUM_PROCS) begin
                n_desc.clk[i] = FIELD_W'(n_clk[i]);
            end
        end
        n_desc.in_snap = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_desc_valid <= 1'b0;
            r_seen       <= '0;
            r_active     <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++) begin
                r_clk[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                for (int i = 0; i < NUM_PROCS; i++) begin
                    r_clk[i] <= n_clk[i];
                end
                r_seen       <= n_seen;
                r_active     <= n_active;
                r_desc_valid <= n_desc_ok;
            end else if (i_desc_done) begin
                r_desc_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd  <= i_cmd;
            r_peer <= i_peer;
            r_recv <= i_recv;
        end
        if (fire) begin
            r_desc <= n_desc;
        end
    end

endmodule

// File: sv/vcsn_seq.sv
// Result sequencer: first result of an item, then one marker per peer.
`timescale 1ns / 1ps

module vcsn_seq import vcsn_pkg::*; #(
    parameter int NUM_PROCS = NUM_PROCS_DEF,
    localparam int IDX_W    = $clog2(NUM_PROCS),
    localparam int J_W      = IDX_W + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_desc_valid,
    input  t_desc                     i_desc,
    input  logic [IDX_W-1:0]          i_own_idx,
    output logic                      o_desc_done,
    output logic                      o_valid,
    input  logic                      i_ready,
    output t_kind                     o_kind,
    output logic [PEER_W-1:0]         o_peer,
    output logic [NUM_ENT-1:0][FIELD_W-1:0] o_clk,
    output logic                      o_in_snap,
    output logic                      o_last
);

    typedef enum logic {
        PH_FIRST,
        PH_MARK
    } t_phase;

    t_phase                        r_phase;
    logic [J_W-1:0]                r_j;
    logic                          r_valid;
    t_kind                         r_kind;
    logic [PEER_W-1:0]             r_peer;
    logic [NUM_ENT-1:0][FIELD_W-1:0] r_clk;
    logic                          r_in_snap;
    logic                          r_last;

    logic [J_W-1:0]                own_j;
    logic [J_W-1:0]                first_j;
    logic [J_W-1:0]                j_inc;
    logic [J_W-1:0]                j_next;
    logic                          mk_last;
    logic                          take;
    logic                          out_last;

    assign own_j   = J_W'(i_own_idx);
    assign first_j = (own_j == '0) ? J_W'(1) : '0;
    assign j_inc   = r_j + 1'b1;
    assign j_next  = (j_inc == own_j) ? r_j + J_W'(2) : j_inc;
    assign mk_last = 32'(j_next) >= NUM_PROCS;

    assign take        = i_desc_valid && (!r_valid || i_ready);
    assign out_last    = (r_phase == PH_FIRST) ? !i_desc.has_markers : mk_last;
    assign o_desc_done = take && out_last;

    assign o_valid   = r_valid;
    assign o_kind    = r_kind;
    assign o_peer    = r_peer;
    assign o_clk     = r_clk;
    assign o_in_snap = r_in_snap;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_j     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_last  <= out_last;
                unique case (r_phase)
                    PH_FIRST: begin
                        r_kind    <= i_desc.kind;
                        r_peer    <= i_desc.peer;
                        r_clk     <= i_desc.clk;
                        r_in_snap <= i_desc.in_snap;
                        if (i_desc.has_markers) begin
                            r_phase <= PH_MARK;
                            r_j     <= first_j;
                        end
                    end
                    PH_MARK: begin
                        r_kind    <= KIND_MARKER;
                        r_peer    <= PEER_W'(r_j);
                        r_clk     <= '0;
                        r_in_snap <= 1'b1;
                        r_j       <= j_next;
                        if (mk_last) begin
                            r_phase <= PH_FIRST;
                        end
                    end
                    default: begin
                        r_phase <= PH_FIRST;
                    end
                endcase
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: sv/vector_clock_snapshot_node.sv
// Top level of the vector clock snapshot node: stream ports and register port.
`timescale 1ns / 1ps

// One node of a small message-passing system: it keeps a saturating vector
// clock and the marker state of a consistent-snapshot protocol. Each slave
// transaction carries one event (internal, send, receive, marker, or start
// snapshot) and produces one or more master transactions (none for an
// unknown command); the last result of an event has tlast set. Internal,
// send, receive and later-marker commands give one result each: the node
// accepts a new event every cycle while the output keeps up, passing it
// through the input register, the descriptor register (state update) and
// the result register. A first marker or a start command gives NUM_PROCS
// results (the recorded local clock, then one marker per peer in ascending
// order), one per cycle through the single result register while the master
// accepts them; events behind it wait in the input register. Results stall
// cleanly under master backpressure. The own_rank register sits at byte
// address 0; it must be written only while the node is idle, which the block
// does not enforce. A rank of NUM_PROCS or more acts as the highest rank.
module vector_clock_snapshot_node import vcsn_pkg::*; #(
    parameter int NUM_PROCS  = NUM_PROCS_DEF,
    parameter int CLOCK_BITS = CLOCK_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Event stream in
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,  // peer, recv_c0, recv_c1, recv_c2, zero fill
    input  logic [CMD_W-1:0]     i_s_tuser,  // cmd

    // Result stream out
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_DATA_W-1:0]  o_m_tdata,  // peer_out, clk0, clk1, clk2, in_snapshot, zero fill
    output logic [KIND_W-1:0]    o_m_tuser,  // kind
    output logic                 o_m_tlast,  // last

    // Register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    localparam int IDX_W = $clog2(NUM_PROCS);

    logic [RANK_W-1:0]               r_own_rank;
    logic [NUM_ENT-1:0][FIELD_W-1:0] recv;
    logic [IDX_W-1:0]                own_idx;
    logic                            desc_valid;
    t_desc                           desc;
    logic                            desc_done;
    t_kind                           out_kind;
    logic [PEER_W-1:0]               out_peer;
    logic [NUM_ENT-1:0][FIELD_W-1:0] out_clk;
    logic                            out_in_snap;
    logic                            reg_sel;

    // Register decode: word index is paddr[2]; only word 0 exists.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_OWN_RANK);
    assign prdata  = reg_sel ? APB_DW'(r_own_rank) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_rank <= '0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_own_rank <= pwdata[RANK_W-1:0];
        end
    end

    // Unpack received clock entries from tdata.
    for (genvar g = 0; g < NUM_ENT; g++) begin : g_unpack
        assign recv[g] = i_s_tdata[PEER_W + g*FIELD_W +: FIELD_W];
    end

    vcsn_core #(
        .NUM_PROCS  (NUM_PROCS),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_cmd        (i_s_tuser),
        .i_peer       (i_s_tdata[PEER_W-1:0]),
        .i_recv       (recv),
        .i_own_rank   (r_own_rank),
        .o_own_idx    (own_idx),
        .o_desc_valid (desc_valid),
        .o_desc       (desc),
        .i_desc_done  (desc_done)
    );

    vcsn_seq #(
        .NUM_PROCS (NUM_PROCS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc       (desc),
        .i_own_idx    (own_idx),
        .o_desc_done  (desc_done),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_kind       (out_kind),
        .o_peer       (out_peer),
        .o_clk        (out_clk),
        .o_in_snap    (out_in_snap),
        .o_last       (o_m_tlast)
    );

    // Pack the result; zero fill up to the byte boundary.
    assign o_m_tuser = out_kind;
    assign o_m_tdata = M_DATA_W'({out_in_snap, out_clk[2], out_clk[1], out_clk[0], out_peer});

endmodule

// File: tb/tb_vector_clock_snapshot_node.sv
// Self-checking testbench for the vector clock snapshot node.
`timescale 1ns / 1ps

// Drives event transactions into the node, predicts every result transaction
// from a local copy of the clock vector and marker state, and compares each
// result against the oldest prediction. A directed list comes first and covers
// saturation, out-of-range peers and ranks, repeated starts, snapshot
// completion and the unused commands. Random phases follow, each under its own
// own_rank setting. The sender runs in bursts. The receiver stalls on a
// rotating pattern and once holds off long enough to back the node up.
module tb_vector_clock_snapshot_node;
    import vcsn_pkg::*;

    localparam int          DRAIN_CYCLES       = 16;
    localparam int          IDLE_LIMIT         = 3000;
    localparam int          HOLD_CYCLES        = 300;
    localparam int          PHASE_EVENTS       = 48;
    localparam int          FLOOD_EVENTS       = 40;
    localparam int          NUM_PHASES         = 6;
    localparam int          MAX_REPORTED       = 10;
    localparam int          FILL_W             = S_DATA_W - PEER_W - 3 * FIELD_W;
    localparam logic [FIELD_W-1:0] CLK_SAT     = {FIELD_W{1'b1}};
    localparam logic [APB_AW-1:0]  RANK_ADDR   = APB_AW'(4 * REG_OWN_RANK);

    // Command codes the node must ignore.
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        t_kind               kind;
        logic [PEER_W-1:0]   peer;
        logic [FIELD_W-1:0]  c0;
        logic [FIELD_W-1:0]  c1;
        logic [FIELD_W-1:0]  c2;
        logic                in_snap;
        logic                is_last;
    } t_report;

    typedef enum logic {ROW_EVENT, ROW_RANK} t_row_op;

    typedef struct packed {
        t_row_op             op;
        logic [CMD_W-1:0]    cmd;
        logic [PEER_W-1:0]   peer;
        logic [FIELD_W-1:0]  r0;
        logic [FIELD_W-1:0]  r1;
        logic [FIELD_W-1:0]  r2;
        logic                typed;
        t_report             first;
    } t_row;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata  = '0;
    logic [CMD_W-1:0]     i_s_tuser  = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic [KIND_W-1:0]    o_m_tuser;
    logic                 o_m_tlast;
    logic                 psel       = 1'b0;
    logic                 penable    = 1'b0;
    logic                 pwrite     = 1'b0;
    logic [APB_AW-1:0]    paddr      = '0;
    logic [APB_DW-1:0]    pwdata     = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    vector_clock_snapshot_node dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Local copy of the node state, advanced once per accepted event.
    logic [FIELD_W-1:0]  node_clock [NUM_ENT];
    logic                node_seen  [NUM_ENT];
    logic                node_active;
    logic [RANK_W-1:0]   node_rank;

    t_report  pending_reports [$];
    t_row     directed_rows   [$];
    int       mismatches  = 0;
    int       idle_cycles = 0;
    logic     hold_start  = 1'b0;

    // A rank past the last process acts as the last process.
    function automatic int own_slot();
        return (node_rank >= NUM_PROCS_DEF) ? NUM_PROCS_DEF - 1 : int'(node_rank);
    endfunction

    function automatic void bump_own_entry();
        int r;
        r = own_slot();
        if (node_clock[r] != CLK_SAT)
            node_clock[r] = node_clock[r] + 1'b1;
    endfunction

    function automatic void post_report(t_kind kind, logic [PEER_W-1:0] peer,
                                        logic with_clock, logic is_last);
        t_report rep;
        rep.kind    = kind;
        rep.peer    = peer;
        rep.c0      = with_clock ? node_clock[0] : '0;
        rep.c1      = with_clock ? node_clock[1] : '0;
        rep.c2      = with_clock ? node_clock[2] : '0;
        rep.in_snap = node_active;
        rep.is_last = is_last;
        pending_reports.push_back(rep);
    endfunction

    // Record the local clock, then one marker to every other process in
    // ascending order; tlast goes on the highest destination.
    function automatic void record_local(logic [PEER_W-1:0] peer_field);
        int r;
        int last_dest;
        r = own_slot();
        last_dest = (r == NUM_PROCS_DEF - 1) ? NUM_PROCS_DEF - 2 : NUM_PROCS_DEF - 1;
        node_active = 1'b1;
        node_seen[r] = 1'b1;
        post_report(KIND_RECORD, peer_field, 1'b1, 1'b0);
        for (int j = 0; j < NUM_PROCS_DEF; j++) begin
            if (j != r)
                post_report(KIND_MARKER, PEER_W'(j), 1'b0, j == last_dest);
        end
    endfunction

    function automatic void apply_event(logic [CMD_W-1:0] cmd, logic [PEER_W-1:0] peer,
                                        logic [FIELD_W-1:0] r0, logic [FIELD_W-1:0] r1,
                                        logic [FIELD_W-1:0] r2);
        logic [FIELD_W-1:0] recv [NUM_ENT];
        logic all_seen;
        int r;
        recv[0] = r0;
        recv[1] = r1;
        recv[2] = r2;
        r = own_slot();
        case (cmd)
            CMD_INTERNAL: begin
                bump_own_entry();
                post_report(KIND_CLOCK, '0, 1'b1, 1'b1);
            end
            CMD_SEND: begin
                bump_own_entry();
                post_report(KIND_MSG, peer, 1'b1, 1'b1);
            end
            CMD_RECV: begin
                bump_own_entry();
                for (int i = 0; i < NUM_PROCS_DEF; i++) begin
                    if (i != r && recv[i] > node_clock[i])
                        node_clock[i] = recv[i];
                end
                post_report(KIND_CLOCK, peer, 1'b1, 1'b1);
            end
            CMD_MARKER: begin
                if (peer < NUM_PROCS_DEF)
                    node_seen[peer] = 1'b1;
                if (!node_active) begin
                    record_local(peer);
                end else begin
                    all_seen = node_seen[0] & node_seen[1] & node_seen[2];
                    if (all_seen) begin
                        node_active = 1'b0;
                        for (int i = 0; i < NUM_ENT; i++)
                            node_seen[i] = 1'b0;
                        post_report(KIND_DONE, peer, 1'b1, 1'b1);
                    end else begin
                        post_report(KIND_NOTED, peer, 1'b1, 1'b1);
                    end
                end
            end
            CMD_START: record_local(PEER_W'(r));
            default: ;
        endcase
    endfunction

    task automatic add_row(t_row_op op, logic [CMD_W-1:0] cmd, logic [PEER_W-1:0] peer,
                           logic [FIELD_W-1:0] r0, logic [FIELD_W-1:0] r1,
                           logic [FIELD_W-1:0] r2, logic typed = 1'b0,
                           t_kind k = KIND_CLOCK, logic [PEER_W-1:0] p = '0,
                           logic [FIELD_W-1:0] e0 = '0, logic [FIELD_W-1:0] e1 = '0,
                           logic [FIELD_W-1:0] e2 = '0, logic snap = 1'b0);
        t_row row;
        row.op            = op;
        row.cmd           = cmd;
        row.peer          = peer;
        row.r0            = r0;
        row.r1            = r1;
        row.r2            = r2;
        row.typed         = typed;
        row.first.kind    = k;
        row.first.peer    = p;
        row.first.c0      = e0;
        row.first.c1      = e1;
        row.first.c2      = e2;
        row.first.in_snap = snap;
        row.first.is_last = 1'b0;
        directed_rows.push_back(row);
    endtask

    // Offer one event and hold it until the node takes it; base returns where
    // its predictions start in the queue.
    task automatic offer_event(logic [CMD_W-1:0] cmd, logic [PEER_W-1:0] peer,
                               logic [FIELD_W-1:0] r0, logic [FIELD_W-1:0] r1,
                               logic [FIELD_W-1:0] r2, output int base);
        i_s_tuser  <= cmd;
        i_s_tdata  <= {{FILL_W{1'b0}}, r2, r1, r0, peer};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        base = pending_reports.size();
        apply_event(cmd, peer, r0, r1, r2);
    endtask

    task automatic idle_gap(int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // Write own_rank only once the node has gone quiet; unused commands give
    // no result, so let a few more cycles pass after the last one.
    task automatic write_rank(logic [RANK_W-1:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= RANK_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        node_rank = value;
    endtask

    function automatic logic [FIELD_W-1:0] pick_recv(int slot);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CLK_SAT;
            2:       return node_clock[slot] + FIELD_W'($urandom_range(0, 4)) - 16'd2;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // Weighted toward receives and markers so snapshots open and close often.
    function automatic logic [CMD_W-1:0] pick_cmd();
        int w;
        w = $urandom_range(0, 99);
        if (w < 14) return CMD_INTERNAL;
        if (w < 28) return CMD_SEND;
        if (w < 55) return CMD_RECV;
        if (w < 82) return CMD_MARKER;
        if (w < 90) return CMD_START;
        return CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
    endfunction

    task automatic log_mismatch(string why, t_report want, t_report got);
        mismatches++;
        if (mismatches <= MAX_REPORTED)
            $display("%0t mismatch (%s): expected kind %0d peer %0d clk %h %h %h snap %b last %b,",
                     $realtime, why, want.kind, want.peer, want.c0, want.c1, want.c2,
                     want.in_snap, want.is_last,
                     " got kind %0d peer %0d clk %h %h %h snap %b last %b",
                     got.kind, got.peer, got.c0, got.c1, got.c2, got.in_snap, got.is_last);
    endtask

    // Result side: check every transaction, then pick next cycle's tready.
    int rx_cycle   = 0;
    int hold_left  = 0;
    bit hold_taken = 1'b0;

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        rx_cycle++;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind    = t_kind'(o_m_tuser);
            got.peer    = o_m_tdata[PEER_W-1:0];
            got.c0      = o_m_tdata[PEER_W +: FIELD_W];
            got.c1      = o_m_tdata[PEER_W + FIELD_W +: FIELD_W];
            got.c2      = o_m_tdata[PEER_W + 2 * FIELD_W +: FIELD_W];
            got.in_snap = o_m_tdata[PEER_W + 3 * FIELD_W];
            got.is_last = o_m_tlast;
            if (pending_reports.size() == 0) begin
                log_mismatch("no result outstanding", '0, got);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want)
                    log_mismatch("field", want, got);
            end
        end
        if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 400) % 4)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= 1'($urandom_range(0, 1));
                2:       i_m_tready <= (rx_cycle % 3 != 0);
                default: i_m_tready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        $display("vector_clock_snapshot_node test failed");
        $finish;
    end

    initial begin
        t_row               row;
        t_report            typed_first;
        int                 base;
        int                 counted;
        int                 burst_left;
        logic [CMD_W-1:0]   cmd;
        logic [PEER_W-1:0]  peer;
        logic [FIELD_W-1:0] v0;
        logic [FIELD_W-1:0] v1;
        logic [FIELD_W-1:0] v2;
        logic [RANK_W-1:0]  phase_rank [NUM_PHASES];

        for (int i = 0; i < NUM_ENT; i++) begin
            node_clock[i] = '0;
            node_seen[i]  = 1'b0;
        end
        node_active = 1'b0;
        node_rank   = '0;
        phase_rank  = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd0, 2'd2};

        // Rank 0 after reset. Typed rows give the first result outright.
        add_row(ROW_EVENT, CMD_INTERNAL, 2'd3, 16'hFFFF, 16'h0000, 16'hFFFF,
                1'b1, KIND_CLOCK, 2'd0, 16'd1, 16'd0, 16'd0, 1'b0);
        add_row(ROW_EVENT, CMD_SEND, 2'd2, 16'h1234, 16'h5678, 16'h9ABC,
                1'b1, KIND_MSG, 2'd2, 16'd2, 16'd0, 16'd0, 1'b0);
        // Receive at the top of the range; the own entry is never taken over.
        add_row(ROW_EVENT, CMD_RECV, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                1'b1, KIND_CLOCK, 2'd1, 16'd3, 16'hFFFF, 16'hFFFF, 1'b0);
        add_row(ROW_EVENT, CMD_RECV, 2'd2, 16'h0000, 16'h0000, 16'h0000);
        // First marker records the local clock and sends markers out.
        add_row(ROW_EVENT, CMD_MARKER, 2'd1, 16'h0000, 16'h0000, 16'h0000,
                1'b1, KIND_RECORD, 2'd1, 16'd4, 16'hFFFF, 16'hFFFF, 1'b1);
        // Channel-state receive from a peer that does not exist.
        add_row(ROW_EVENT, CMD_RECV, 2'd3, 16'h0001, 16'h0002, 16'h0003);
        // Marker from a nonexistent peer sets no flag.
        add_row(ROW_EVENT, CMD_MARKER, 2'd3, 16'hAAAA, 16'h5555, 16'hAAAA);
        add_row(ROW_EVENT, CMD_MARKER, 2'd2, 16'h0000, 16'h0000, 16'h0000,
                1'b1, KIND_DONE, 2'd2, 16'd5, 16'hFFFF, 16'hFFFF, 1'b0);
        add_row(ROW_EVENT, CMD_RSVD5, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_row(ROW_EVENT, CMD_RSVD6, 2'd3, 16'h0000, 16'hFFFF, 16'h0000);
        add_row(ROW_EVENT, CMD_RSVD7, 2'd1, 16'h5555, 16'hAAAA, 16'h5555);
        // Start names the own rank, whatever the peer field says.
        add_row(ROW_EVENT, CMD_START, 2'd3, 16'h0000, 16'h0000, 16'h0000,
                1'b1, KIND_RECORD, 2'd0, 16'd5, 16'hFFFF, 16'hFFFF, 1'b1);
        // Start while a snapshot is active records again.
        add_row(ROW_EVENT, CMD_START, 2'd1, 16'h0000, 16'h0000, 16'h0000);
        add_row(ROW_EVENT, CMD_MARKER, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        add_row(ROW_EVENT, CMD_MARKER, 2'd1, 16'h0000, 16'h0000, 16'h0000);
        add_row(ROW_EVENT, CMD_MARKER, 2'd2, 16'h0000, 16'h0000, 16'h0000,
                1'b1, KIND_DONE, 2'd2, 16'd5, 16'hFFFF, 16'hFFFF, 1'b0);
        // Rank 3 acts as rank 2, whose entry is already saturated.
        add_row(ROW_RANK, '0, '0, 16'd3, '0, '0);
        add_row(ROW_EVENT, CMD_INTERNAL, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                1'b1, KIND_CLOCK, 2'd0, 16'd5, 16'hFFFF, 16'hFFFF, 1'b0);
        add_row(ROW_EVENT, CMD_START, 2'd0, 16'h0000, 16'h0000, 16'h0000,
                1'b1, KIND_RECORD, 2'd2, 16'd5, 16'hFFFF, 16'hFFFF, 1'b1);
        add_row(ROW_EVENT, CMD_SEND, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_row(ROW_EVENT, CMD_MARKER, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        add_row(ROW_EVENT, CMD_MARKER, 2'd1, 16'h0000, 16'h0000, 16'h0000);
        add_row(ROW_RANK, '0, '0, 16'd1, '0, '0);
        add_row(ROW_EVENT, CMD_RECV, 2'd0, 16'hFFFF, 16'h0000, 16'h8000);
        add_row(ROW_EVENT, CMD_INTERNAL, 2'd1, 16'h0000, 16'h0000, 16'h0000);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.op == ROW_RANK) begin
                write_rank(row.r0[RANK_W-1:0]);
            end else begin
                offer_event(row.cmd, row.peer, row.r0, row.r1, row.r2, base);
                if (row.typed) begin
                    typed_first         = row.first;
                    typed_first.is_last = pending_reports[base].is_last;
                    pending_reports[base] = typed_first;
                end
                if ($urandom_range(0, 2) == 0)
                    idle_gap($urandom_range(1, 4));
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_rank(phase_rank[ph]);
            counted    = 0;
            burst_left = $urandom_range(1, 24);
            // First phase: stall the result side and keep offering back to back.
            if (ph == 0)
                hold_start <= 1'b1;
            while (counted < PHASE_EVENTS) begin
                cmd  = pick_cmd();
                peer = PEER_W'($urandom_range(0, 3));
                v0   = pick_recv(0);
                v1   = pick_recv(1);
                v2   = pick_recv(2);
                offer_event(cmd, peer, v0, v1, v2, base);
                if (cmd <= CMD_START)
                    counted++;
                if (ph == 0 && counted < FLOOD_EVENTS) begin
                    // hold valid high while the node backs up
                end else if (ph == 2 && counted == PHASE_EVENTS / 2 && cmd <= CMD_START) begin
                    // pause until every outstanding result has come back
                    wait_drained();
                end else begin
                    burst_left--;
                    if (burst_left <= 0) begin
                        idle_gap($urandom_range(1, 15));
                        burst_left = $urandom_range(1, 24);
                    end
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("vector_clock_snapshot_node test passed");
        else
            $display("vector_clock_snapshot_node test failed");
        $finish;
    end

endmodule

// File: files.f
sv/vcsn_pkg.sv
sv/vcsn_core.sv
sv/vcsn_seq.sv
sv/vector_clock_snapshot_node.sv
tb/tb_vector_clock_snapshot_node.sv
